### sv/cpm_pkg.sv
// cascade position servo: shared types, constants and arithmetic helpers
// no dependencies; used by every other file of the block
package cpm_pkg;

    // defaults of the top level parameters
    localparam int CPR_DEFAULT = 216;
    localparam int PWM_DEFAULT = 100;

    // field and datapath widths
    localparam int OP_W       = 2;
    localparam int DT_W       = 8;
    localparam int REF_W      = 16;
    localparam int DUTY_W     = 7;
    localparam int Q_W        = 32;
    localparam int INT_W      = 48;
    localparam int ITAE_W     = 63;
    localparam int GAIN_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int DIVIDEND_W = 48;
    localparam int DIVISOR_W  = 16;
    localparam int MUL_W      = 33;
    localparam int PROD_W     = 2 * MUL_W;

    // gain reset values, unsigned Q16.16
    localparam logic [GAIN_W-1:0] POS_KP_RST = 32'd32768;
    localparam logic [GAIN_W-1:0] POS_KI_RST = 32'd0;
    localparam logic [GAIN_W-1:0] POS_KD_RST = 32'd65536;
    localparam logic [GAIN_W-1:0] VEL_KP_RST = 32'd163840000;
    localparam logic [GAIN_W-1:0] VEL_KI_RST = 32'd0;
    localparam logic [GAIN_W-1:0] VEL_KD_RST = 32'd2621440000;

    // saturation limits
    localparam logic signed [63:0] LIM32_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] LIM32_LO = -64'sh0000_0000_8000_0000;
    localparam logic signed [63:0] LIM48_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] LIM48_LO = -64'sh0000_8000_0000_0000;
    localparam logic [63:0]        TERM_LIM = 64'h1000_0000_0000_0000;
    localparam logic [47:0]        PH_LIM   = 48'h1000_0000_0000;
    localparam logic [ITAE_W-1:0]  ITAE_MAX = {ITAE_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_EDGE_A = 2'd0,
        OP_EDGE_B = 2'd1,
        OP_TICK   = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POS_KP = 3'd0,
        CFG_POS_KI = 3'd1,
        CFG_POS_KD = 3'd2,
        CFG_VEL_KP = 3'd3,
        CFG_VEL_KI = 3'd4,
        CFG_VEL_KD = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        DIV_POS  = 2'd0,
        DIV_VEL  = 2'd1,
        DIV_PDER = 2'd2,
        DIV_VDER = 2'd3
    } div_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_INT_MUL,
        ST_INT_ADD,
        ST_TERM_LO,
        ST_TERM_HI,
        ST_TERM_ACC,
        ST_LOOP_END,
        ST_ITAE_MUL,
        ST_ITAE_LO,
        ST_ITAE_HI,
        ST_ITAE_ADD,
        ST_OUT
    } state_t;

    // request to the shared divider
    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > LIM32_HI)
            r = 32'sh7FFF_FFFF;
        else if (v < LIM32_LO)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
        logic signed [47:0] r;
        if (v > LIM48_HI)
            r = 48'sh7FFF_FFFF_FFFF;
        else if (v < LIM48_LO)
            r = 48'sh8000_0000_0000;
        else
            r = v[47:0];
        return r;
    endfunction

    // combine the two partial products of a gain term, saturate to 2^60, apply sign
    function automatic logic signed [63:0] term_fin(input logic [47:0] ph,
                                                    input logic [63:0] lo,
                                                    input logic        neg);
        logic [63:0] r;
        if (ph >= PH_LIM)
            r = TERM_LIM;
        else
            r = {ph, 16'h0000} + {16'h0000, lo[63:16]};
        if (r > TERM_LIM)
            r = TERM_LIM;
        return neg ? -$signed(r) : $signed(r);
    endfunction

endpackage

### sv/cpm_ifs.sv
// cascade position servo: valid/ready channel interfaces
// depends on cpm_pkg for field widths
interface cpm_req_if;
    logic                                valid;
    logic                                ready;
    logic [cpm_pkg::OP_W-1:0]            op;
    logic                                level_a;
    logic                                level_b;
    logic [cpm_pkg::DT_W-1:0]            dt_ms;
    logic signed [cpm_pkg::REF_W-1:0]    reference_position;
    logic                                new_segment;

    modport source (output valid, op, level_a, level_b, dt_ms, reference_position,
                    new_segment, input ready);
    modport sink (input valid, op, level_a, level_b, dt_ms, reference_position,
                  new_segment, output ready);
endinterface

interface cpm_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [cpm_pkg::DUTY_W-1:0]          pwm_forward;
    logic [cpm_pkg::DUTY_W-1:0]          pwm_reverse;
    logic signed [cpm_pkg::Q_W-1:0]      position_error;
    logic [cpm_pkg::ITAE_W-1:0]          itae_total;

    modport source (output valid, pwm_forward, pwm_reverse, position_error, itae_total,
                    input ready);
    modport sink (input valid, pwm_forward, pwm_reverse, position_error, itae_total,
                  output ready);
endinterface

### sv/cpm_mul.sv
// cascade position servo: shared signed multiplier with registered product
// depends on cpm_pkg for operand widths
module cpm_mul (
    input  logic                                 clk,
    input  logic signed [cpm_pkg::MUL_W-1:0]     a,
    input  logic signed [cpm_pkg::MUL_W-1:0]     b,
    output logic signed [cpm_pkg::PROD_W-1:0]    p
);

    logic signed [cpm_pkg::PROD_W-1:0] p_reg;

    // one product per cycle; the product is registered and appears in the next cycle
    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

### sv/cpm_div.sv
// cascade position servo: shared restoring divider, one quotient bit per cycle
// depends on cpm_pkg for the request struct and widths
module cpm_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  cpm_pkg::div_req_t                  req,
    output logic                               done,
    output logic [cpm_pkg::DIVIDEND_W-1:0]     quotient
);

    localparam int NW    = cpm_pkg::DIVIDEND_W;
    localparam int DW    = cpm_pkg::DIVISOR_W;
    localparam int CNT_W = $clog2(NW + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NW-1:0]    quo_reg;
    logic [DW-1:0]    rem_reg;
    logic [DW-1:0]    dvs_reg;
    logic [DW:0]      shifted;
    logic [DW:0]      diff;
    logic             ge;

    // trial subtraction of one step
    always_comb
    begin
        shifted = {rem_reg, quo_reg[NW-1]};
        diff    = shifted - {1'b0, dvs_reg};
        ge      = shifted >= {1'b0, dvs_reg};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    // quotient and remainder shift
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NW-2:0], ge};
            rem_reg <= ge ? diff[DW-1:0] : shifted[DW-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### sv/cascade_pid_motor_position.sv
// cascade position servo top level: sequencer, state and shared datapath
// depends on cpm_pkg, cpm_ifs, cpm_mul, cpm_div
//
//  channel  dir  handshake          word
//  req      in   valid/ready        op, level_a, level_b, dt_ms, reference_position,
//                                   new_segment
//  rsp      out  valid/ready        pwm_forward, pwm_reverse, position_error, itae_total
//  cfg      in   cfg_we             cfg_index, cfg_data (no read-back)
//
// encoder edge words give no result and do not stall req; unknown op is dropped.
// a tick runs four divisions on the shared divider (position, velocity and
// two derivatives) plus the integral, gain term and itae products on the multiplier.
// rsp is a holding register: req is taken again as soon as the tick has finished.
// rst_n clears count, loop history, itae and gains to their reset values.
module cascade_pid_motor_position #(
    parameter int COUNTS_PER_REV = cpm_pkg::CPR_DEFAULT,
    parameter int PWM_RANGE      = cpm_pkg::PWM_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    cpm_req_if.sink                              req,
    cpm_rsp_if.source                            rsp,
    input  logic                                 cfg_we,
    input  logic [cpm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [cpm_pkg::GAIN_W-1:0]           cfg_data
);

    localparam int PW = cpm_pkg::PROD_W;

    cpm_pkg::state_t   state_reg, state_next;
    cpm_pkg::div_sel_t div_idx_reg;
    logic              loop_reg;
    logic [1:0]        term_reg;

    // gains
    logic [31:0] pos_kp_reg, pos_ki_reg, pos_kd_reg;
    logic [31:0] vel_kp_reg, vel_ki_reg, vel_kd_reg;

    // loop state
    logic [31:0]        count_reg;
    logic signed [31:0] prev_pos_reg, prev_perr_reg, prev_verr_reg;
    logic signed [47:0] pint_reg, vint_reg;
    logic [62:0]        itae_reg;
    logic [31:0]        st_reg;

    // work registers of one tick
    logic [7:0]         dt_reg;
    logic signed [15:0] refv_reg;
    logic signed [31:0] pos_reg, err_reg, vel_reg, der_reg, verr_reg;
    logic signed [63:0] acc_reg;
    logic [63:0]        lo_reg;
    logic [38:0]        iprod_reg;
    logic [63:0]        plo_reg;

    // result holding register
    logic        rsp_valid_reg;
    logic [6:0]  fwd_reg, rev_reg;
    logic signed [31:0] perr_out_reg;
    logic [62:0] itae_out_reg;

    logic               accept;
    logic               in_ready;
    cpm_pkg::div_req_t  div_req;
    logic               div_done;
    logic [47:0]        div_q;
    logic signed [48:0] div_sd;
    logic signed [48:0] div_mag;
    logic               div_neg;
    logic signed [48:0] div_qs;
    logic signed [31:0] div_qsat;
    logic signed [31:0] err_new;
    logic signed [MUL_A_W-1:0] mul_a, mul_b;
    logic signed [PW-1:0] mul_p;
    logic signed [47:0] tv;
    logic [31:0]        tg;
    logic [47:0]        tmag;
    logic [31:0]        emag;
    logic signed [31:0] vref;
    logic [71:0]        itae_full;
    logic [63:0]        itae_sum;
    logic [62:0]        itae_new;
    logic [32:0]        st_sum;
    logic               rsp_free;

    localparam int MUL_A_W = cpm_pkg::MUL_W;

    function automatic logic [6:0] duty(input logic signed [63:0] x);
        logic [47:0] d;
        if (x <= 64'sd0)
            d = '0;
        else
            d = x[63:16];
        if (d > 48'(PWM_RANGE))
            d = 48'(PWM_RANGE);
        return d[6:0];
    endfunction

    // shared units
    cpm_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    cpm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    assign accept   = req.valid && in_ready;
    assign rsp_free = !rsp_valid_reg || rsp.ready;

    // dividend select and signed quotient
    always_comb
    begin
        unique case (div_idx_reg)
            cpm_pkg::DIV_POS:  div_sd = {count_reg[31], count_reg, 16'h0000};
            cpm_pkg::DIV_VEL:  div_sd = 49'(pos_reg) - 49'(prev_pos_reg);
            cpm_pkg::DIV_PDER: div_sd = 49'(err_reg) - 49'(prev_perr_reg);
            default:           div_sd = 49'(verr_reg) - 49'(prev_verr_reg);
        endcase
        div_neg  = div_sd[48];
        div_mag  = div_neg ? -div_sd : div_sd;
        div_qs   = div_neg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
        div_qsat = cpm_pkg::sat32(64'(div_qs));
        err_new  = cpm_pkg::sat32(64'($signed({refv_reg, 16'h0000})) - 64'(div_qsat));
    end

    // gain term operand select
    always_comb
    begin
        unique case (term_reg)
            2'd0:    tv = loop_reg ? 48'(verr_reg) : 48'(err_reg);
            2'd1:    tv = loop_reg ? vint_reg : pint_reg;
            default: tv = 48'(der_reg);
        endcase
        unique case (term_reg)
            2'd0:    tg = loop_reg ? vel_kp_reg : pos_kp_reg;
            2'd1:    tg = loop_reg ? vel_ki_reg : pos_ki_reg;
            default: tg = loop_reg ? vel_kd_reg : pos_kd_reg;
        endcase
        tmag = tv[47] ? 48'(-tv) : 48'(tv);
        emag = err_reg[31] ? 32'(-err_reg) : 32'(err_reg);
        vref = cpm_pkg::sat32(acc_reg);
        st_sum = {1'b0, st_reg} + 33'(dt_reg);
    end

    // itae accumulate with saturation
    always_comb
    begin
        itae_full = {33'h0, mul_p[38:0]} << 32;
        itae_full = itae_full + 72'(plo_reg);
        itae_sum  = {1'b0, itae_reg} + itae_full[63:0];
        if (itae_full > 72'(cpm_pkg::ITAE_MAX))
            itae_new = cpm_pkg::ITAE_MAX;
        else if (itae_sum > 64'(cpm_pkg::ITAE_MAX))
            itae_new = cpm_pkg::ITAE_MAX;
        else
            itae_new = itae_sum[62:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cpm_pkg::ST_IDLE:
                if (accept && req.op == cpm_pkg::OP_TICK)
                    state_next = cpm_pkg::ST_DIV_GO;
            cpm_pkg::ST_DIV_GO:
                state_next = cpm_pkg::ST_DIV_WAIT;
            cpm_pkg::ST_DIV_WAIT:
                if (div_done)
                begin
                    priority if (div_idx_reg == cpm_pkg::DIV_POS)
                        state_next = cpm_pkg::ST_DIV_GO;
                    else if (div_idx_reg == cpm_pkg::DIV_VEL)
                        state_next = cpm_pkg::ST_INT_MUL;
                    else
                        state_next = cpm_pkg::ST_TERM_LO;
                end
            cpm_pkg::ST_INT_MUL:  state_next = cpm_pkg::ST_INT_ADD;
            cpm_pkg::ST_INT_ADD:  state_next = cpm_pkg::ST_DIV_GO;
            cpm_pkg::ST_TERM_LO:  state_next = cpm_pkg::ST_TERM_HI;
            cpm_pkg::ST_TERM_HI:  state_next = cpm_pkg::ST_TERM_ACC;
            cpm_pkg::ST_TERM_ACC:
                state_next = (term_reg == 2'd2) ? cpm_pkg::ST_LOOP_END : cpm_pkg::ST_TERM_LO;
            cpm_pkg::ST_LOOP_END:
                state_next = loop_reg ? cpm_pkg::ST_ITAE_MUL : cpm_pkg::ST_INT_MUL;
            cpm_pkg::ST_ITAE_MUL: state_next = cpm_pkg::ST_ITAE_LO;
            cpm_pkg::ST_ITAE_LO:  state_next = cpm_pkg::ST_ITAE_HI;
            cpm_pkg::ST_ITAE_HI:  state_next = cpm_pkg::ST_ITAE_ADD;
            cpm_pkg::ST_ITAE_ADD: state_next = cpm_pkg::ST_OUT;
            cpm_pkg::ST_OUT:
                if (rsp_free)
                    state_next = cpm_pkg::ST_IDLE;
            default: state_next = cpm_pkg::ST_IDLE;
        endcase
    end

    // state decoded controls: ready, divider start, multiplier operands
    always_comb
    begin
        in_ready         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = div_mag[47:0];
        div_req.divisor  = (div_idx_reg == cpm_pkg::DIV_POS) ? 16'(COUNTS_PER_REV)
                                                             : 16'(dt_reg);
        mul_a            = '0;
        mul_b            = '0;
        unique case (state_reg)
            cpm_pkg::ST_IDLE:
                in_ready = 1'b1;
            cpm_pkg::ST_DIV_GO:
                div_req.start = 1'b1;
            cpm_pkg::ST_INT_MUL:
            begin
                mul_a = loop_reg ? 33'(verr_reg) : 33'(err_reg);
                mul_b = 33'(dt_reg);
            end
            cpm_pkg::ST_TERM_LO:
            begin
                mul_a = {1'b0, tmag[31:0]};
                mul_b = {1'b0, tg};
            end
            cpm_pkg::ST_TERM_HI:
            begin
                mul_a = 33'(tmag[47:32]);
                mul_b = {1'b0, tg};
            end
            cpm_pkg::ST_ITAE_MUL:
            begin
                mul_a = {1'b0, emag};
                mul_b = 33'(dt_reg);
            end
            cpm_pkg::ST_ITAE_LO:
            begin
                mul_a = {1'b0, mul_p[31:0]};
                mul_b = {1'b0, st_reg};
            end
            cpm_pkg::ST_ITAE_HI:
            begin
                mul_a = 33'(iprod_reg[38:32]);
                mul_b = {1'b0, st_reg};
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // control, gains and loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cpm_pkg::ST_IDLE;
            div_idx_reg   <= cpm_pkg::DIV_POS;
            loop_reg      <= 1'b0;
            term_reg      <= 2'd0;
            rsp_valid_reg <= 1'b0;
            pos_kp_reg    <= cpm_pkg::POS_KP_RST;
            pos_ki_reg    <= cpm_pkg::POS_KI_RST;
            pos_kd_reg    <= cpm_pkg::POS_KD_RST;
            vel_kp_reg    <= cpm_pkg::VEL_KP_RST;
            vel_ki_reg    <= cpm_pkg::VEL_KI_RST;
            vel_kd_reg    <= cpm_pkg::VEL_KD_RST;
            count_reg     <= '0;
            prev_pos_reg  <= '0;
            prev_perr_reg <= '0;
            prev_verr_reg <= '0;
            pint_reg      <= '0;
            vint_reg      <= '0;
            itae_reg      <= '0;
            st_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;

            // configuration writes
            if (cfg_we)
            begin
                unique case (cfg_index)
                    cpm_pkg::CFG_POS_KP: pos_kp_reg <= cfg_data;
                    cpm_pkg::CFG_POS_KI: pos_ki_reg <= cfg_data;
                    cpm_pkg::CFG_POS_KD: pos_kd_reg <= cfg_data;
                    cpm_pkg::CFG_VEL_KP: vel_kp_reg <= cfg_data;
                    cpm_pkg::CFG_VEL_KI: vel_ki_reg <= cfg_data;
                    cpm_pkg::CFG_VEL_KD: vel_kd_reg <= cfg_data;
                    default: ;
                endcase
            end

            // output handshake
            if (state_reg == cpm_pkg::ST_OUT && rsp_free)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;

            unique case (state_reg)
                cpm_pkg::ST_IDLE:
                    if (accept)
                    begin
                        unique case (req.op)
                            cpm_pkg::OP_EDGE_A:
                                count_reg <= (req.level_a == req.level_b) ?
                                             count_reg + 32'd1 : count_reg - 32'd1;
                            cpm_pkg::OP_EDGE_B:
                                count_reg <= (req.level_a != req.level_b) ?
                                             count_reg + 32'd1 : count_reg - 32'd1;
                            cpm_pkg::OP_TICK:
                            begin
                                div_idx_reg <= cpm_pkg::DIV_POS;
                                loop_reg    <= 1'b0;
                                term_reg    <= 2'd0;
                                // new segment restarts the loop history
                                if (req.new_segment)
                                begin
                                    pint_reg      <= '0;
                                    vint_reg      <= '0;
                                    prev_perr_reg <= '0;
                                    prev_verr_reg <= '0;
                                    itae_reg      <= '0;
                                    st_reg        <= '0;
                                end
                            end
                            default: ;
                        endcase
                    end
                cpm_pkg::ST_DIV_WAIT:
                    if (div_done)
                    begin
                        if (div_idx_reg == cpm_pkg::DIV_POS)
                            div_idx_reg <= cpm_pkg::DIV_VEL;
                        else if (div_idx_reg == cpm_pkg::DIV_VEL)
                            prev_pos_reg <= pos_reg;
                        term_reg <= 2'd0;
                    end
                cpm_pkg::ST_INT_ADD:
                begin
                    if (loop_reg)
                    begin
                        vint_reg    <= cpm_pkg::sat48(64'(vint_reg) + 64'(mul_p));
                        div_idx_reg <= cpm_pkg::DIV_VDER;
                    end
                    else
                    begin
                        pint_reg    <= cpm_pkg::sat48(64'(pint_reg) + 64'(mul_p));
                        div_idx_reg <= cpm_pkg::DIV_PDER;
                    end
                end
                cpm_pkg::ST_TERM_ACC:
                    term_reg <= term_reg + 2'd1;
                cpm_pkg::ST_LOOP_END:
                begin
                    loop_reg <= 1'b1;
                    term_reg <= 2'd0;
                end
                cpm_pkg::ST_ITAE_MUL:
                    st_reg <= st_sum[32] ? 32'hFFFF_FFFF : st_sum[31:0];
                cpm_pkg::ST_ITAE_ADD:
                begin
                    itae_reg      <= itae_new;
                    prev_verr_reg <= verr_reg;
                    prev_perr_reg <= err_reg;
                    // exact zero error drops both integrals
                    if (err_reg == 32'sd0)
                    begin
                        pint_reg <= '0;
                        vint_reg <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath work registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            cpm_pkg::ST_IDLE:
                if (accept)
                begin
                    dt_reg   <= (req.dt_ms == 8'd0) ? 8'd1 : req.dt_ms;
                    refv_reg <= req.reference_position;
                end
            cpm_pkg::ST_DIV_WAIT:
                if (div_done)
                begin
                    priority if (div_idx_reg == cpm_pkg::DIV_POS)
                    begin
                        pos_reg <= div_qsat;
                        err_reg <= err_new;
                    end
                    else if (div_idx_reg == cpm_pkg::DIV_VEL)
                        vel_reg <= div_qsat;
                    else
                        der_reg <= div_qsat;
                end
            cpm_pkg::ST_INT_MUL:
                acc_reg <= '0;
            cpm_pkg::ST_TERM_HI:
                lo_reg <= mul_p[63:0];
            cpm_pkg::ST_TERM_ACC:
                acc_reg <= acc_reg + cpm_pkg::term_fin(mul_p[47:0], lo_reg, tv[47]);
            cpm_pkg::ST_LOOP_END:
                if (!loop_reg)
                    verr_reg <= cpm_pkg::sat32(64'(vref) - 64'(vel_reg));
            cpm_pkg::ST_ITAE_LO:
                iprod_reg <= mul_p[38:0];
            cpm_pkg::ST_ITAE_HI:
                plo_reg <= mul_p[63:0];
            cpm_pkg::ST_OUT:
                if (rsp_free)
                begin
                    fwd_reg      <= (err_reg > 32'sd0) ? duty(acc_reg) : 7'd0;
                    rev_reg      <= (err_reg > 32'sd0) ? 7'd0 : duty(-acc_reg);
                    perr_out_reg <= err_reg;
                    itae_out_reg <= itae_reg;
                end
            default: ;
        endcase
    end

    assign req.ready          = in_ready;
    assign rsp.valid          = rsp_valid_reg;
    assign rsp.pwm_forward    = fwd_reg;
    assign rsp.pwm_reverse    = rev_reg;
    assign rsp.position_error = perr_out_reg;
    assign rsp.itae_total     = itae_out_reg;

    // a tick holds off further words while it runs
    a_tick_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.op == cpm_pkg::OP_TICK) |=> !req.ready)
        else $error("req taken during tick processing");

    // an encoder edge never stalls the input
    a_edge_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready &&
         (req.op == cpm_pkg::OP_EDGE_A || req.op == cpm_pkg::OP_EDGE_B)) |=> req.ready)
        else $error("edge word stalled input");

    // only one drive direction at a time
    a_one_dir: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.pwm_forward == 7'd0 || rsp.pwm_reverse == 7'd0))
        else $error("both pwm directions driven");

    // forward drive only on positive error
    a_fwd_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !(rsp.position_error > 32'sd0)) |-> rsp.pwm_forward == 7'd0)
        else $error("forward pwm without positive error");

endmodule

### bench/tb_cascade_pid_motor_position.sv
// testbench for the cascade position servo: directed and random encoder/tick words
// depends on cpm_pkg, cpm_ifs and the cascade_pid_motor_position rtl
module tb_cascade_pid_motor_position;
    import cpm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;
    localparam int              IDLE_WAIT  = 400;
    localparam longint          HI32 = 64'sd2147483647;
    localparam longint          LO32 = -64'sd2147483648;
    localparam longint          HI48 = 64'sd140737488355327;
    localparam longint          LO48 = -64'sd140737488355328;
    localparam logic [63:0]     TERM_SAT = 64'h1000_0000_0000_0000;
    localparam logic [63:0]     ITAE_SAT = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic [DUTY_W-1:0] fwd;
        logic [DUTY_W-1:0] rev;
        logic [Q_W-1:0]    perr;
        logic [ITAE_W-1:0] itae;
    } servo_out_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [GAIN_W-1:0]    cfg_data;

    cpm_req_if req_ch();
    cpm_rsp_if rsp_ch();

    cascade_pid_motor_position uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // servo model state
    logic [GAIN_W-1:0] gain [6];
    logic [31:0]  enc_count;
    longint       last_pos, last_perr, pos_integ, last_verr, vel_integ;
    logic [63:0]  itae_acc;
    logic [31:0]  seg_ms;

    servo_out_t expected_out [$];
    bit         failed;
    int         send_idle_pct;
    int         recv_idle_pct;
    logic       enc_a, enc_b;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    initial
    begin
        #20000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // magnitude * gain >> 16, sign applied after, saturated to 2^60
    function automatic longint gain_term(input longint v, input logic [31:0] g);
        logic [63:0] mag, ph, lo, r;
        bit neg;
        neg = v < 0;
        mag = neg ? 64'(-v) : 64'(v);
        ph  = (mag >> 32) * {32'h0, g};
        lo  = mag & 64'hFFFF_FFFF;
        if (ph >= (64'h1 << 44))
            r = TERM_SAT;
        else
            r = (ph << 16) + ((lo * {32'h0, g}) >> 16);
        if (r > TERM_SAT)
            r = TERM_SAT;
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint pid_out(input longint e, inout longint integ,
                                       input longint prev, input longint dt,
                                       input logic [31:0] kp, input logic [31:0] ki,
                                       input logic [31:0] kd);
        longint der;
        integ = clip(integ + e * dt, LO48, HI48);
        der = clip((e - prev) / dt, LO32, HI32);
        return gain_term(e, kp) + gain_term(integ, ki) + gain_term(der, kd);
    endfunction

    function automatic logic [DUTY_W-1:0] duty_of(input longint v);
        longint d;
        d = v / 65536;
        d = clip(d, 0, PWM_DEFAULT);
        return d[DUTY_W-1:0];
    endfunction

    function automatic void model_reset();
        gain[CFG_POS_KP] = POS_KP_RST;
        gain[CFG_POS_KI] = POS_KI_RST;
        gain[CFG_POS_KD] = POS_KD_RST;
        gain[CFG_VEL_KP] = VEL_KP_RST;
        gain[CFG_VEL_KI] = VEL_KI_RST;
        gain[CFG_VEL_KD] = VEL_KD_RST;
        enc_count = '0;
        last_pos = 0; last_perr = 0; pos_integ = 0;
        last_verr = 0; vel_integ = 0;
        itae_acc = '0; seg_ms = '0;
    endfunction

    // advance the servo model by one accepted word
    function automatic void servo_predict(input logic [OP_W-1:0] op, input logic la,
                                          input logic lb, input logic [7:0] dt_in,
                                          input logic signed [15:0] ref_rev,
                                          input logic nseg);
        longint dt, pos, err, vel, vref, verr, vout;
        logic [63:0] mag, prod;
        servo_out_t o;
        bit up;
        if (op == OP_EDGE_A || op == OP_EDGE_B)
        begin
            up = (la == lb) ? (op == OP_EDGE_A) : (op == OP_EDGE_B);
            enc_count = up ? enc_count + 1 : enc_count - 1;
            return;
        end
        if (op != OP_TICK)
            return;
        dt = (dt_in == 0) ? 1 : longint'(dt_in);
        if (nseg)
        begin
            pos_integ = 0; vel_integ = 0; last_perr = 0; last_verr = 0;
            itae_acc = '0; seg_ms = '0;
        end
        pos = clip(longint'(signed'(enc_count)) * 65536 / CPR_DEFAULT, LO32, HI32);
        err = clip(longint'(ref_rev) * 65536 - pos, LO32, HI32);
        vel = clip((pos - last_pos) / dt, LO32, HI32);
        last_pos = pos;
        vref = clip(pid_out(err, pos_integ, last_perr, dt, gain[CFG_POS_KP],
                            gain[CFG_POS_KI], gain[CFG_POS_KD]), LO32, HI32);
        verr = clip(vref - vel, LO32, HI32);
        vout = pid_out(verr, vel_integ, last_verr, dt, gain[CFG_VEL_KP],
                       gain[CFG_VEL_KI], gain[CFG_VEL_KD]);
        // segment time and itae, both saturating
        if ({32'h0, seg_ms} + 64'(dt) > 64'hFFFF_FFFF)
            seg_ms = 32'hFFFF_FFFF;
        else
            seg_ms = seg_ms + 32'(dt);
        mag  = err < 0 ? 64'(-err) : 64'(err);
        prod = mag * 64'(dt);
        if (seg_ms != 0 && prod > ITAE_SAT / {32'h0, seg_ms})
            itae_acc = ITAE_SAT;
        else
        begin
            prod = prod * {32'h0, seg_ms};
            itae_acc = (prod > ITAE_SAT - itae_acc) ? ITAE_SAT : itae_acc + prod;
        end
        if (err > 0)
        begin
            o.fwd = duty_of(vout);
            o.rev = '0;
        end
        else
        begin
            o.fwd = '0;
            o.rev = duty_of(-vout);
        end
        o.perr = err[31:0];
        o.itae = itae_acc[ITAE_W-1:0];
        expected_out.push_back(o);
        last_verr = verr;
        last_perr = err;
        if (err == 0)
        begin
            pos_integ = 0;
            vel_integ = 0;
        end
    endfunction

    // send one word; valid stays high into the next word when there is no gap
    task automatic send_word(input logic [OP_W-1:0] op, input logic la, input logic lb,
                             input logic [7:0] dt, input logic signed [15:0] ref_rev,
                             input logic nseg);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        req_ch.valid              <= 1'b1;
        req_ch.op                 <= op;
        req_ch.level_a            <= la;
        req_ch.level_b            <= lb;
        req_ch.dt_ms              <= dt;
        req_ch.reference_position <= ref_rev;
        req_ch.new_segment        <= nseg;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        servo_predict(op, la, lb, dt, ref_rev, nseg);
    endtask

    // wait for all results and let the block settle before touching gains
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_out.size() != 0)
            @(posedge clk);
        repeat (IDLE_WAIT) @(posedge clk);
    endtask

    task automatic write_gain(input cfg_idx_t idx, input logic [GAIN_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        gain[idx] = v;
    endtask

    task automatic write_all_gains(input logic [GAIN_W-1:0] pkp, input logic [GAIN_W-1:0] pki,
                                   input logic [GAIN_W-1:0] pkd, input logic [GAIN_W-1:0] vkp,
                                   input logic [GAIN_W-1:0] vki, input logic [GAIN_W-1:0] vkd);
        wait_drained();
        write_gain(CFG_POS_KP, pkp);
        write_gain(CFG_POS_KI, pki);
        write_gain(CFG_POS_KD, pkd);
        write_gain(CFG_VEL_KP, vkp);
        write_gain(CFG_VEL_KI, vki);
        write_gain(CFG_VEL_KD, vkd);
        @(posedge clk);
    endtask

    // one quadrature step that keeps the levels consistent
    task automatic step_encoder(input bit up);
        if ((enc_a == enc_b) ^ up)
        begin
            enc_a = ~enc_a;
            send_word(OP_EDGE_A, enc_a, enc_b, 8'd0, 16'sd0, 1'b0);
        end
        else
        begin
            enc_b = ~enc_b;
            send_word(OP_EDGE_B, enc_a, enc_b, 8'd0, 16'sd0, 1'b0);
        end
    endtask

    // extremes, every op, zero error, zero dt, new segment, dropped op
    task automatic test_directed();
        send_word(OP_TICK, 1'b0, 1'b0, 8'd10, 16'sd0, 1'b1);
        send_word(OP_TICK, 1'b1, 1'b1, 8'd0, 16'sd32767, 1'b0);
        send_word(OP_TICK, 1'b0, 1'b0, 8'd255, -16'sd32768, 1'b0);
        send_word(OP_TICK, 1'b0, 1'b0, 8'd1, 16'sd1, 1'b1);
        send_word(OP_UNUSED, 1'b1, 1'b0, 8'd7, 16'sd5, 1'b1);
        for (int i = 0; i < 4; i++)
        begin
            send_word(OP_EDGE_A, i[0], i[1], 8'd0, 16'sd0, 1'b0);
            send_word(OP_EDGE_B, i[0], i[1], 8'd0, 16'sd0, 1'b0);
        end
        send_word(OP_TICK, 1'b0, 1'b0, 8'd2, -16'sd1, 1'b0);
        send_word(OP_TICK, 1'b0, 1'b0, 8'd3, 16'sd0, 1'b0);
        send_word(OP_TICK, 1'b0, 1'b0, 8'd128, 16'sd0, 1'b1);
        enc_a = 1'b0;
        enc_b = 1'b0;
    endtask

    // segments of consistent encoder motion and ticks, with some noise
    task automatic test_random_motion(input int n_words);
        int sent;
        int burst;
        bit up;
        logic signed [15:0] target;
        sent = 0;
        target = 16'sd0;
        while (sent < n_words)
        begin
            if ($urandom_range(9) == 0)
            begin
                send_word(logic'($urandom_range(3)), $urandom_range(1), $urandom_range(1),
                          8'($urandom), 16'($urandom), $urandom_range(1));
                sent++;
            end
            else
            begin
                burst = $urandom_range(2) == 0 ? $urandom_range(60) : $urandom_range(8);
                up = $urandom_range(1);
                for (int i = 0; i < burst; i++)
                    step_encoder(up);
                sent += burst;
                if ($urandom_range(7) == 0)
                    target = $urandom_range(3) == 0 ? 16'($urandom)
                                                    : 16'($signed($urandom_range(4)) - 2);
                send_word(OP_TICK, 1'b0, 1'b0,
                          $urandom_range(4) == 0 ? 8'($urandom) : 8'($urandom_range(20, 2)),
                          target, $urandom_range(11) == 0);
                sent++;
            end
        end
    endtask

    // response checking against the oldest expectation
    always @(posedge clk)
    begin
        servo_out_t e;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_out.size() == 0)
            begin
                $error("unexpected result word");
                failed = 1'b1;
            end
            else
            begin
                e = expected_out.pop_front();
                if (rsp_ch.pwm_forward !== e.fwd)
                begin
                    $error("pwm_forward exp %0d got %0d", e.fwd, rsp_ch.pwm_forward);
                    failed = 1'b1;
                end
                if (rsp_ch.pwm_reverse !== e.rev)
                begin
                    $error("pwm_reverse exp %0d got %0d", e.rev, rsp_ch.pwm_reverse);
                    failed = 1'b1;
                end
                if (rsp_ch.position_error !== e.perr)
                begin
                    $error("position_error exp %h got %h", e.perr, rsp_ch.position_error);
                    failed = 1'b1;
                end
                if (rsp_ch.itae_total !== e.itae)
                begin
                    $error("itae_total exp %h got %h", e.itae, rsp_ch.itae_total);
                    failed = 1'b1;
                end
            end
        end
    end

    // receiver stalls
    always @(posedge clk)
    begin
        rsp_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    initial
    begin
        failed        = 1'b0;
        send_idle_pct = 24;
        recv_idle_pct = 74;
        enc_a = 1'b0;
        enc_b = 1'b0;
        model_reset();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_POS_KP;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.op = OP_EDGE_A;
        req_ch.level_a = 1'b0;
        req_ch.level_b = 1'b0;
        req_ch.dt_ms = '0;
        req_ch.reference_position = '0;
        req_ch.new_segment = 1'b0;
        rsp_ch.ready = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_motion(250);

        // gain extremes and mixes, idling swapped
        send_idle_pct = 74;
        recv_idle_pct = 24;
        write_all_gains('0, '0, '0, '0, '0, '0);
        test_random_motion(60);
        write_all_gains('1, '1, '1, '1, '1, '1);
        test_random_motion(80);
        write_all_gains(32'h0001_0000, 32'h0000_0100, 32'h0002_0000,
                        32'h0100_0000, 32'h0000_4000, 32'h2000_0000);
        test_random_motion(200);

        // no idling
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_all_gains($urandom, $urandom_range(65535), $urandom, $urandom,
                        $urandom_range(1 << 20), $urandom);
        test_random_motion(200);
        write_all_gains(POS_KP_RST, POS_KI_RST, POS_KD_RST,
                        VEL_KP_RST, VEL_KI_RST, VEL_KD_RST);
        test_random_motion(250);

        wait_drained();
        if (!failed && expected_out.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
